[rtl/lrsm_pkg.sv]
// Shared types and codes for the link retry state machine.
`timescale 1ns / 1ps

package lrsm_pkg;

    typedef enum logic [2:0] {
        OP_START     = 3'd0,
        OP_CONNECTED = 3'd1,
        OP_RECONNECT = 3'd2,
        OP_LINK_ERR  = 3'd3,
        OP_TICK      = 3'd4,
        OP_HALT      = 3'd5
    } op_e;

    typedef enum logic [2:0] {
        REG_CONNECT_TIMEOUT = 3'd0,
        REG_RECONNECT_DELAY = 3'd1,
        REG_HAS_INIT_HOOK   = 3'd2,
        REG_HAS_OPEN_HOOK   = 3'd3,
        REG_HAS_CLOSE_HOOK  = 3'd4,
        REG_HAS_FAILED_HOOK = 3'd5
    } reg_idx_e;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef struct packed {
        logic [15:0] connect_timeout_ticks;
        logic [15:0] reconnect_delay_ticks;
        logic        has_init_hook;
        logic        has_open_hook;
        logic        has_close_hook;
        logic        has_failed_hook;
    } cfg_t;

    typedef struct packed {
        logic [2:0] operation;
        logic       init_ok;
        logic       open_ok;
        logic       fail_verdict_halt;
    } item_t;

    typedef struct packed {
        logic [2:0] link_state;
        logic       init_request;
        logic       open_request;
        logic       close_request;
        logic       fail_notice;
        logic [2:0] fail_prev_state;
    } res_t;

endpackage

[rtl/lrsm_cfg.sv]
// Configuration register file for the link retry state machine.
`timescale 1ns / 1ps

module lrsm_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lrsm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lrsm_pkg::CFG_DATA_W-1:0]     cfg_data,
    output lrsm_pkg::cfg_t                      cfg
);

    lrsm_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lrsm_pkg::REG_CONNECT_TIMEOUT: cfg_reg.connect_timeout_ticks <= cfg_data;
                lrsm_pkg::REG_RECONNECT_DELAY: cfg_reg.reconnect_delay_ticks <= cfg_data;
                lrsm_pkg::REG_HAS_INIT_HOOK:   cfg_reg.has_init_hook   <= cfg_data[0];
                lrsm_pkg::REG_HAS_OPEN_HOOK:   cfg_reg.has_open_hook   <= cfg_data[0];
                lrsm_pkg::REG_HAS_CLOSE_HOOK:  cfg_reg.has_close_hook  <= cfg_data[0];
                lrsm_pkg::REG_HAS_FAILED_HOOK: cfg_reg.has_failed_hook <= cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

[rtl/lrsm_core.sv]
// Link state, timers and the combinational event transition chain.
`timescale 1ns / 1ps

module lrsm_core
#(
    parameter int TIMER_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  lrsm_pkg::item_t   item,
    input  lrsm_pkg::cfg_t    cfg,
    output lrsm_pkg::res_t    res
);

    localparam int LOADW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    typedef enum logic [2:0] {
        ST_HALTED     = 3'd0,
        ST_INIT       = 3'd1,
        ST_CONNECTING = 3'd2,
        ST_CONNECTED  = 3'd3,
        ST_FAILED     = 3'd4,
        ST_TIMEOUT    = 3'd5
    } state_e;

    typedef struct packed {
        state_e                st;
        logic                  closed;
        logic [TIMER_BITS-1:0] c_cnt;
        logic                  c_arm;
        logic [TIMER_BITS-1:0] r_cnt;
        logic                  r_arm;
        logic                  o_init;
        logic                  o_open;
        logic                  o_close;
        logic                  o_fail;
        state_e                o_prev;
    } work_t;

    state_e                state_reg;
    logic                  closed_reg;
    logic [TIMER_BITS-1:0] c_cnt_reg;
    logic                  c_arm_reg;
    logic [TIMER_BITS-1:0] r_cnt_reg;
    logic                  r_arm_reg;

    work_t  w;
    logic   do_init;
    logic   do_conn;
    logic   do_fail;
    logic   do_halt;
    state_e fail_prev;

    // Saturate a 16-bit register value into the counter range.
    function automatic logic [TIMER_BITS-1:0] timer_load(input logic [15:0] v);
        logic [LOADW-1:0] ext;
        logic [LOADW-1:0] maxv;
        ext  = LOADW'(v);
        maxv = LOADW'({TIMER_BITS{1'b1}});
        return (ext > maxv) ? {TIMER_BITS{1'b1}} : TIMER_BITS'(ext);
    endfunction

    function automatic work_t go_halted(input work_t wi, input logic close_hook);
        work_t r;
        r = wi;
        r.st = ST_HALTED;
        if (close_hook && !wi.closed)
        begin
            r.o_close = 1'b1;
        end
        r.closed = 1'b1;
        r.c_arm  = 1'b0;
        r.c_cnt  = '0;
        r.r_arm  = 1'b0;
        r.r_cnt  = '0;
        return r;
    endfunction

    function automatic work_t fail_core(input work_t wi, input state_e prev,
                                        input lrsm_pkg::cfg_t c, input logic verdict);
        work_t r;
        r = wi;
        r.c_arm = 1'b0;
        r.c_cnt = '0;
        r.st    = ST_FAILED;
        if (c.has_close_hook && !r.closed)
        begin
            r.o_close = 1'b1;
        end
        r.closed = 1'b1;
        if (c.has_failed_hook)
        begin
            r.o_fail = 1'b1;
            r.o_prev = prev;
        end
        if (c.has_failed_hook && verdict)
        begin
            r = go_halted(r, c.has_close_hook);
        end
        else if (prev != ST_TIMEOUT)
        begin
            r.r_arm = 1'b1;
            r.r_cnt = timer_load(c.reconnect_delay_ticks);
        end
        return r;
    endfunction

    always_comb
    begin
        w.st      = state_reg;
        w.closed  = closed_reg;
        w.c_cnt   = c_cnt_reg;
        w.c_arm   = c_arm_reg;
        w.r_cnt   = r_cnt_reg;
        w.r_arm   = r_arm_reg;
        w.o_init  = 1'b0;
        w.o_open  = 1'b0;
        w.o_close = 1'b0;
        w.o_fail  = 1'b0;
        w.o_prev  = ST_HALTED;
        do_init   = 1'b0;
        do_conn   = 1'b0;
        do_fail   = 1'b0;
        do_halt   = 1'b0;
        fail_prev = state_reg;

        case (item.operation)
            lrsm_pkg::OP_START:
            begin
                do_init = (state_reg == ST_HALTED);
            end
            lrsm_pkg::OP_CONNECTED:
            begin
                do_conn = (state_reg == ST_CONNECTING);
            end
            lrsm_pkg::OP_RECONNECT:
            begin
                do_init = (state_reg == ST_HALTED);
                do_fail = (state_reg == ST_CONNECTING) || (state_reg == ST_CONNECTED);
            end
            lrsm_pkg::OP_LINK_ERR:
            begin
                do_fail = (state_reg == ST_CONNECTING) || (state_reg == ST_CONNECTED);
            end
            lrsm_pkg::OP_TICK:
            begin
                // connect timer has priority; count of 0 or 1 fires
                if (c_arm_reg)
                begin
                    if (c_cnt_reg[TIMER_BITS-1:1] == '0)
                    begin
                        w.c_arm   = 1'b0;
                        w.c_cnt   = '0;
                        do_fail   = 1'b1;
                        fail_prev = ST_TIMEOUT;
                    end
                    else
                    begin
                        w.c_cnt = c_cnt_reg - TIMER_BITS'(1);
                    end
                end
                else if (r_arm_reg)
                begin
                    if (r_cnt_reg[TIMER_BITS-1:1] == '0)
                    begin
                        w.r_arm = 1'b0;
                        w.r_cnt = '0;
                        do_init = 1'b1;
                    end
                    else
                    begin
                        w.r_cnt = r_cnt_reg - TIMER_BITS'(1);
                    end
                end
            end
            lrsm_pkg::OP_HALT:
            begin
                do_halt = (state_reg != ST_HALTED);
            end
            default: ;
        endcase

        if (do_conn)
        begin
            w.st    = ST_CONNECTED;
            w.c_arm = 1'b0;
            w.c_cnt = '0;
            if (cfg.has_open_hook)
            begin
                w.o_open = 1'b1;
                if (!item.open_ok)
                begin
                    do_fail   = 1'b1;
                    fail_prev = ST_CONNECTED;
                end
            end
        end

        if (do_fail)
        begin
            w = fail_core(w, fail_prev, cfg, item.fail_verdict_halt);
            // timeout failure retries init in the same item unless the failed hook verdict halts
            if (fail_prev == ST_TIMEOUT && !(cfg.has_failed_hook && item.fail_verdict_halt))
            begin
                do_init = 1'b1;
            end
        end

        if (do_init)
        begin
            w.r_arm = 1'b0;
            w.r_cnt = '0;
            w.st    = ST_INIT;
            if (cfg.has_init_hook)
            begin
                w.o_init = 1'b1;
            end
            if (!cfg.has_init_hook || item.init_ok)
            begin
                w.closed = 1'b0;
                w.st     = ST_CONNECTING;
                if (cfg.connect_timeout_ticks != '0)
                begin
                    w.c_arm = 1'b1;
                    w.c_cnt = timer_load(cfg.connect_timeout_ticks);
                end
            end
            else
            begin
                w = fail_core(w, ST_INIT, cfg, item.fail_verdict_halt);
            end
        end

        if (do_halt)
        begin
            w = go_halted(w, cfg.has_close_hook);
        end
    end

    assign res.link_state      = w.st;
    assign res.init_request    = w.o_init;
    assign res.open_request    = w.o_open;
    assign res.close_request   = w.o_close;
    assign res.fail_notice     = w.o_fail;
    assign res.fail_prev_state = w.o_prev;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_HALTED;
            closed_reg <= 1'b0;
            c_cnt_reg  <= '0;
            c_arm_reg  <= 1'b0;
            r_cnt_reg  <= '0;
            r_arm_reg  <= 1'b0;
        end
        else if (step_en)
        begin
            state_reg  <= w.st;
            closed_reg <= w.closed;
            c_cnt_reg  <= w.c_cnt;
            c_arm_reg  <= w.c_arm;
            r_cnt_reg  <= w.r_cnt;
            r_arm_reg  <= w.r_arm;
        end
    end

`ifndef SYNTHESIS
    a_no_transient_state: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_INIT && state_reg != ST_TIMEOUT)
        else $error("transient link state held");

    a_connect_timer_state: assert property (@(posedge clk) disable iff (!rst_n)
        c_arm_reg |-> state_reg == ST_CONNECTING)
        else $error("connect timer armed outside connecting");

    a_retry_timer_state: assert property (@(posedge clk) disable iff (!rst_n)
        r_arm_reg |-> state_reg == ST_FAILED)
        else $error("retry timer armed outside failed");

    a_open_link_not_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONNECTING || state_reg == ST_CONNECTED) |-> !closed_reg)
        else $error("link marked closed while open");

    a_open_from_connecting: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && res.open_request) |=> $past(state_reg) == ST_CONNECTING)
        else $error("open request outside connecting");
`endif

endmodule

[rtl/link_retry_state_machine.sv]
// Top level: link retry state machine with input and result registers.
`timescale 1ns / 1ps

// Channel | Signals                                        | Direction
// in      | in_valid, in_ready, operation, init_ok,        | item in
//         | open_ok, fail_verdict_halt                     |
// out     | out_valid, out_ready, link_state, init_request,| result out
//         | open_request, close_request, fail_notice,      |
//         | fail_prev_state                                |
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data      | register write
//
// One item per cycle sustained while results are taken; an item lands first in the
// input register, and the result register loads from it once the output can take it.
// The whole transition chain of an item resolves combinationally in the core logic.
// Reset leaves the link halted, timers disarmed and the control, timer and config
// registers zero; item and result registers are not reset. A stalled result holds the
// output register; the input register still takes one more item, then in_ready drops until the result is taken.

module link_retry_state_machine
#(
    parameter int TIMER_BITS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [2:0]                          operation,
    input  logic                                init_ok,
    input  logic                                open_ok,
    input  logic                                fail_verdict_halt,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [2:0]                          link_state,
    output logic                                init_request,
    output logic                                open_request,
    output logic                                close_request,
    output logic                                fail_notice,
    output logic [2:0]                          fail_prev_state,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lrsm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lrsm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    lrsm_pkg::cfg_t  cfg;
    lrsm_pkg::item_t item_reg;
    lrsm_pkg::res_t  res;
    lrsm_pkg::res_t  res_reg;
    logic            in_valid_reg;
    logic            out_valid_reg;
    logic            step_en;

    assign step_en  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step_en;

    lrsm_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lrsm_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (step_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.operation         <= operation;
            item_reg.init_ok           <= init_ok;
            item_reg.open_ok           <= open_ok;
            item_reg.fail_verdict_halt <= fail_verdict_halt;
        end
        if (step_en)
        begin
            res_reg <= res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign link_state      = res_reg.link_state;
    assign init_request    = res_reg.init_request;
    assign open_request    = res_reg.open_request;
    assign close_request   = res_reg.close_request;
    assign fail_notice     = res_reg.fail_notice;
    assign fail_prev_state = res_reg.fail_prev_state;

endmodule
